/* hw/rtl/array_min_priority_queue_macros.svh */
// Assertion macros for the priority queue RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define APQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apq: implication check failed");
`define APQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apq: next-cycle check failed");
`else
`define APQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define APQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/apq_pkg.sv */
package apq_pkg;

    localparam int STATUS_W = 2;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDLAST = 5'b00010,
        S_MOVE   = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

endpackage

/* hw/rtl/apq_if.sv */
interface apq_req_if #(
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [TAG_BITS-1:0]      task_tag;
    logic [PRIORITY_BITS-1:0] priority_req;

    modport source (output valid, op, task_tag, priority_req, input ready);
    modport sink   (input valid, op, task_tag, priority_req, output ready);
endinterface

interface apq_rsp_if #(
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int COUNT_BITS    = 5
);
    logic                         valid;
    logic                         ready;
    logic [apq_pkg::STATUS_W-1:0] status;
    logic [TAG_BITS-1:0]          served_tag;
    logic [PRIORITY_BITS-1:0]     served_priority;
    logic                         head_valid;
    logic [TAG_BITS-1:0]          head_tag;
    logic [PRIORITY_BITS-1:0]     head_priority;
    logic                         is_empty;
    logic [COUNT_BITS-1:0]        task_count;

    modport source (output valid, status, served_tag, served_priority, head_valid,
                    head_tag, head_priority, is_empty, task_count, input ready);
    modport sink   (input valid, status, served_tag, served_priority, head_valid,
                    head_tag, head_priority, is_empty, task_count, output ready);
endinterface

/* hw/rtl/apq_ram.sv */
module apq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/apq_head_scan.sv */
// Running minimum over entries streamed out of the store, lowest index wins ties.
module apq_head_scan #(
    parameter int IDX_W         = 4,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_vld,
    input  logic                     i_first,
    input  logic [IDX_W-1:0]         i_idx,
    input  logic [TAG_BITS-1:0]      i_tag,
    input  logic [PRIORITY_BITS-1:0] i_pri,
    output logic [IDX_W-1:0]         o_idx,
    output logic [TAG_BITS-1:0]      o_tag,
    output logic [PRIORITY_BITS-1:0] o_pri
);
    logic [IDX_W-1:0]         r_idx;
    logic [TAG_BITS-1:0]      r_tag;
    logic [PRIORITY_BITS-1:0] r_pri;
    logic                     w_take;

    assign w_take = i_vld && (i_first || (i_pri < r_pri));

    // Best so far including the entry arriving this cycle.
    always_comb begin
        o_idx = w_take ? i_idx : r_idx;
        o_tag = w_take ? i_tag : r_tag;
        o_pri = w_take ? i_pri : r_pri;
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_idx <= o_idx;
            r_tag <= o_tag;
            r_pri <= o_pri;
        end
    end
endmodule

/* hw/rtl/array_min_priority_queue.sv */
// Channel  Dir  Payload                                                   Accept
// i_req    in   op, task_tag, priority_req                                valid & ready
// o_rsp    out  status, served_tag/priority, head_valid/tag/priority,     valid & ready
//               is_empty, task_count
//
// Insert, full insert and empty extract go straight from S_IDLE to S_FIN for the response.
// Extract: S_RDLAST reads the last entry and S_MOVE writes it into the hole; unless the
// queue is now empty, the single read port rescans the remaining entries one per cycle.
// The head entry is cached, so inserts need no scan.
// i_rst_n is synchronous; the store itself is not cleared, only the count and control state.
// A held response does not block the next request; the work waits only to publish.
`include "array_min_priority_queue_macros.svh"

module array_min_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    apq_req_if.sink    i_req,
    apq_rsp_if.source  o_rsp
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = TAG_BITS + PRIORITY_BITS;

    apq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_head_vld, n_head_vld;
    logic [IDX_W-1:0]         r_head_idx, n_head_idx;
    logic [TAG_BITS-1:0]      r_head_tag, n_head_tag;
    logic [PRIORITY_BITS-1:0] r_head_pri, n_head_pri;
    apq_pkg::t_status         r_status, n_status;
    logic [TAG_BITS-1:0]      r_srv_tag, n_srv_tag;
    logic [PRIORITY_BITS-1:0] r_srv_pri, n_srv_pri;
    logic [CNT_W-1:0]         r_rd_addr, n_rd_addr;
    logic                     r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]         r_chk_idx, n_chk_idx;

    logic                         r_out_vld, n_out_vld;
    logic [apq_pkg::STATUS_W-1:0] r_o_status;
    logic [TAG_BITS-1:0]          r_o_srv_tag;
    logic [PRIORITY_BITS-1:0]     r_o_srv_pri;
    logic                         r_o_head_vld;
    logic [TAG_BITS-1:0]          r_o_head_tag;
    logic [PRIORITY_BITS-1:0]     r_o_head_pri;
    logic                         r_o_empty;
    logic [CNT_W-1:0]             r_o_count;

    logic                     w_acc;
    logic                     w_full;
    logic                     w_load;
    logic                     w_issue;
    logic                     w_scan_end;
    logic                     w_we;
    logic [IDX_W-1:0]         w_waddr;
    logic [ENT_W-1:0]         w_wdata;
    logic [IDX_W-1:0]         w_raddr;
    logic [ENT_W-1:0]         w_rdata;
    logic [IDX_W-1:0]         w_best_idx;
    logic [TAG_BITS-1:0]      w_best_tag;
    logic [PRIORITY_BITS-1:0] w_best_pri;

    assign i_req.ready = (r_state == apq_pkg::S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count >= CNT_W'(CAPACITY));
    assign w_load      = (r_state == apq_pkg::S_FIN) && (!r_out_vld || o_rsp.ready);
    assign w_issue     = (r_state == apq_pkg::S_SCAN) && (r_rd_addr < r_count);
    assign w_scan_end  = (r_state == apq_pkg::S_SCAN) && r_chk_vld &&
                         (CNT_W'(r_chk_idx) == (r_count - CNT_W'(1)));

    // Store port muxing: append on insert, fill the hole with the last entry on extract.
    always_comb begin
        w_we    = (w_acc && (i_req.op == apq_pkg::OP_INSERT) && !w_full) ||
                  (r_state == apq_pkg::S_MOVE);
        w_waddr = (r_state == apq_pkg::S_MOVE) ? r_head_idx : r_count[IDX_W-1:0];
        w_wdata = (r_state == apq_pkg::S_MOVE) ? w_rdata
                                                : {i_req.task_tag, i_req.priority_req};
        // Outside the scan the count (already decremented) addresses the last entry.
        w_raddr = (r_state == apq_pkg::S_SCAN) ? r_rd_addr[IDX_W-1:0]
                                                : r_count[IDX_W-1:0];
    end

    apq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    apq_head_scan #(
        .IDX_W         (IDX_W),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_vld   (r_chk_vld && (r_state == apq_pkg::S_SCAN)),
        .i_first (r_chk_idx == '0),
        .i_idx   (r_chk_idx),
        .i_tag   (w_rdata[ENT_W-1:PRIORITY_BITS]),
        .i_pri   (w_rdata[PRIORITY_BITS-1:0]),
        .o_idx   (w_best_idx),
        .o_tag   (w_best_tag),
        .o_pri   (w_best_pri)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head_vld = r_head_vld;
        n_head_idx = r_head_idx;
        n_head_tag = r_head_tag;
        n_head_pri = r_head_pri;
        n_status   = r_status;
        n_srv_tag  = r_srv_tag;
        n_srv_pri  = r_srv_pri;
        n_rd_addr  = r_rd_addr;
        n_chk_vld  = 1'b0;
        n_chk_idx  = r_rd_addr[IDX_W-1:0];
        case (r_state)
            apq_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_srv_tag = '0;
                    n_srv_pri = '0;
                    n_status  = apq_pkg::ST_DONE;
                    n_state   = apq_pkg::S_FIN;
                    if (i_req.op == apq_pkg::OP_INSERT) begin
                        if (w_full) begin
                            n_status = apq_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            // New entry sits at the highest index: it wins only if strictly less.
                            if (!r_head_vld || (i_req.priority_req < r_head_pri)) begin
                                n_head_vld = 1'b1;
                                n_head_idx = r_count[IDX_W-1:0];
                                n_head_tag = i_req.task_tag;
                                n_head_pri = i_req.priority_req;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_status = apq_pkg::ST_EMPTY;
                    end else begin
                        n_srv_tag = r_head_tag;
                        n_srv_pri = r_head_pri;
                        n_count   = r_count - CNT_W'(1);
                        n_state   = apq_pkg::S_RDLAST;
                    end
                end
            end
            apq_pkg::S_RDLAST: begin
                n_state = apq_pkg::S_MOVE;
            end
            apq_pkg::S_MOVE: begin
                // Write lands this edge; scan reads start afterwards.
                n_rd_addr = '0;
                if (r_count == '0) begin
                    n_head_vld = 1'b0;
                    n_state    = apq_pkg::S_FIN;
                end else begin
                    n_state = apq_pkg::S_SCAN;
                end
            end
            apq_pkg::S_SCAN: begin
                n_chk_vld = w_issue;
                if (w_issue) begin
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                end
                if (w_scan_end) begin
                    n_head_vld = 1'b1;
                    n_head_idx = w_best_idx;
                    n_head_tag = w_best_tag;
                    n_head_pri = w_best_pri;
                    n_state    = apq_pkg::S_FIN;
                end
            end
            apq_pkg::S_FIN: begin
                if (w_load) begin
                    n_state = apq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = apq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= apq_pkg::S_IDLE;
            r_count    <= '0;
            r_head_vld <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_head_vld <= n_head_vld;
            r_chk_vld  <= n_chk_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_idx <= n_head_idx;
        r_head_tag <= n_head_tag;
        r_head_pri <= n_head_pri;
        r_status   <= n_status;
        r_srv_tag  <= n_srv_tag;
        r_srv_pri  <= n_srv_pri;
        r_rd_addr  <= n_rd_addr;
        r_chk_idx  <= n_chk_idx;
        if (w_load) begin
            r_o_status   <= r_status;
            r_o_srv_tag  <= r_srv_tag;
            r_o_srv_pri  <= r_srv_pri;
            r_o_head_vld <= r_head_vld;
            r_o_head_tag <= r_head_vld ? r_head_tag : '0;
            r_o_head_pri <= r_head_vld ? r_head_pri : '0;
            r_o_empty    <= (r_count == '0);
            r_o_count    <= r_count;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.served_tag      = r_o_srv_tag;
    assign o_rsp.served_priority = r_o_srv_pri;
    assign o_rsp.head_valid      = r_o_head_vld;
    assign o_rsp.head_tag        = r_o_head_tag;
    assign o_rsp.head_priority   = r_o_head_pri;
    assign o_rsp.is_empty        = r_o_empty;
    assign o_rsp.task_count      = r_o_count;

    `APQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `APQ_ASSERT_IMP(a_head_cache, i_clk, i_rst_n,
                    r_state == apq_pkg::S_IDLE, r_head_vld == (r_count != '0))
    `APQ_ASSERT_NXT(a_empty_extract, i_clk, i_rst_n,
                    w_acc && (i_req.op == apq_pkg::OP_EXTRACT) && (r_count == '0),
                    r_state == apq_pkg::S_FIN)
    `APQ_ASSERT_NXT(a_scan_count, i_clk, i_rst_n, r_state == apq_pkg::S_SCAN, $stable(r_count))
endmodule

/* tb/apq_queue_checker.sv */
module apq_queue_checker #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16,
    parameter int COUNT_BITS    = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    apq_req_if   i_req,
    apq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status                  status;
        logic [TAG_BITS-1:0]      served_tag;
        logic [PRIORITY_BITS-1:0] served_priority;
        logic                     head_valid;
        logic [TAG_BITS-1:0]      head_tag;
        logic [PRIORITY_BITS-1:0] head_priority;
        logic                     is_empty;
        logic [COUNT_BITS-1:0]    task_count;
    } queue_outcome_t;

    // mirror of the task array
    logic [TAG_BITS-1:0]      tag_mirror [CAPACITY];
    logic [PRIORITY_BITS-1:0] prio_mirror[CAPACITY];
    int unsigned              mirror_count;

    queue_outcome_t pending_outcomes[$];
    queue_outcome_t want;
    queue_outcome_t got;
    int             mismatch_count;

    initial begin
        mirror_count   = 0;
        mismatch_count = 0;
    end

    // lowest index wins on equal priorities
    function automatic int unsigned min_slot();
        int unsigned best;
        best = 0;
        for (int unsigned k = 1; k < mirror_count; k++) begin
            if (prio_mirror[k] < prio_mirror[best])
                best = k;
        end
        return best;
    endfunction

    function automatic queue_outcome_t serve_request(t_op op, logic [TAG_BITS-1:0] tag,
                                                     logic [PRIORITY_BITS-1:0] prio);
        queue_outcome_t res;
        int unsigned    slot;
        int unsigned    last;
        res        = '0;
        res.status = ST_DONE;
        if (op == OP_INSERT) begin
            if (mirror_count < CAPACITY) begin
                tag_mirror[mirror_count]  = tag;
                prio_mirror[mirror_count] = prio;
                mirror_count++;
            end else begin
                res.status = ST_FULL;
            end
        end else if (mirror_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            slot                = min_slot();
            last                = mirror_count - 1;
            res.served_tag      = tag_mirror[slot];
            res.served_priority = prio_mirror[slot];
            tag_mirror[slot]    = tag_mirror[last];
            prio_mirror[slot]   = prio_mirror[last];
            mirror_count        = last;
        end
        if (mirror_count != 0) begin
            slot              = min_slot();
            res.head_tag      = tag_mirror[slot];
            res.head_priority = prio_mirror[slot];
        end
        res.head_valid = (mirror_count != 0);
        res.is_empty   = (mirror_count == 0);
        res.task_count = COUNT_BITS'(mirror_count);
        return res;
    endfunction

    function automatic void flag_field(string field, logic [31:0] exp_val,
                                       logic [31:0] act_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: response %s mismatch: expected %h, got %h",
                     $realtime, field, exp_val, act_val);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirror_count = 0;
            pending_outcomes.delete();
        end else begin
            // response side first: a response never belongs to a request of the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                got.status          = t_status'(i_rsp.status);
                got.served_tag      = i_rsp.served_tag;
                got.served_priority = i_rsp.served_priority;
                got.head_valid      = i_rsp.head_valid;
                got.head_tag        = i_rsp.head_tag;
                got.head_priority   = i_rsp.head_priority;
                got.is_empty        = i_rsp.is_empty;
                got.task_count      = i_rsp.task_count;
                if (pending_outcomes.size() == 0) begin
                    flag_field("unrequested", '0, 32'(got.status));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status)
                        flag_field("status", 32'(want.status), 32'(got.status));
                    if (got.served_tag !== want.served_tag)
                        flag_field("served_tag", 32'(want.served_tag), 32'(got.served_tag));
                    if (got.served_priority !== want.served_priority)
                        flag_field("served_priority", 32'(want.served_priority),
                                   32'(got.served_priority));
                    if (got.head_valid !== want.head_valid)
                        flag_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
                    if (got.head_tag !== want.head_tag)
                        flag_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
                    if (got.head_priority !== want.head_priority)
                        flag_field("head_priority", 32'(want.head_priority),
                                   32'(got.head_priority));
                    if (got.is_empty !== want.is_empty)
                        flag_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                    if (got.task_count !== want.task_count)
                        flag_field("task_count", 32'(want.task_count), 32'(got.task_count));
                end
            end
            if (i_req.valid && i_req.ready)
                pending_outcomes.push_back(serve_request(t_op'(i_req.op), i_req.task_tag,
                                                         i_req.priority_req));
        end
        o_pending    <= pending_outcomes.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int TAG_BITS      = 16;
    localparam int COUNT_BITS    = 5;

    localparam int RANDOM_ITEMS  = 950;
    localparam int IDLE_PCT      = 31;
    localparam int HOLD_START    = 1500;
    localparam int HOLD_CYCLES   = 250;
    localparam int STEADY_FIRST  = 3000;
    localparam int STEADY_LAST   = 4000;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    bit   sender_gaps_on;

    apq_req_if #(.TAG_BITS(TAG_BITS), .PRIORITY_BITS(PRIORITY_BITS)) req_ch ();
    apq_rsp_if #(.TAG_BITS(TAG_BITS), .PRIORITY_BITS(PRIORITY_BITS),
                 .COUNT_BITS(COUNT_BITS)) rsp_ch ();

    array_min_priority_queue #(
        .CAPACITY     (CAPACITY),
        .PRIORITY_BITS(PRIORITY_BITS),
        .TAG_BITS     (TAG_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    apq_queue_checker #(
        .CAPACITY     (CAPACITY),
        .PRIORITY_BITS(PRIORITY_BITS),
        .TAG_BITS     (TAG_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (outstanding)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_request(input t_op op, input logic [TAG_BITS-1:0] tag,
                                 input logic [PRIORITY_BITS-1:0] prio);
        while (sender_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.op           = op;
        req_ch.task_tag     = tag;
        req_ch.priority_req = prio;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, one long hold to back the queue up, one steady window
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle     = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else if (rx_cycle >= STEADY_FIRST && rx_cycle < STEADY_LAST) begin
                rsp_ch.ready = 1'b1;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[array_min_priority_queue] ERROR");
        $finish;
    end

    initial begin
        t_op                      op;
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
        int                       insert_bias;
        insert_bias         = 50;
        sender_gaps_on      = 1'b1;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_INSERT;
        req_ch.task_tag     = '0;
        req_ch.priority_req = '0;
        wait (i_rst_n);
        @(negedge i_clk);

        // extract from an empty queue
        offer_request(OP_EXTRACT, 16'hFFFF, 16'hFFFF);
        // extremes, then an equal priority behind the current minimum
        offer_request(OP_INSERT, 16'h0000, 16'hFFFF);
        offer_request(OP_INSERT, 16'hFFFF, 16'h0000);
        offer_request(OP_INSERT, 16'h1234, 16'h0000);
        repeat (3) offer_request(OP_EXTRACT, 16'h0000, 16'h0000);
        offer_request(OP_EXTRACT, 16'h5A5A, 16'hA5A5);
        // fill to capacity with paired ties, then insert into a full queue
        for (int k = 0; k < CAPACITY; k++)
            offer_request(OP_INSERT, 16'hA5A5 ^ TAG_BITS'(k),
                          PRIORITY_BITS'((CAPACITY - 1 - k) >> 1));
        offer_request(OP_INSERT, 16'hFFFF, 16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // phases that drain, churn or fill the queue
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       insert_bias = 15;
                    1:       insert_bias = 50;
                    default: insert_bias = 85;
                endcase
            end
            sender_gaps_on = !(n >= 400 && n < 550);
            op  = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_EXTRACT;
            tag = TAG_BITS'($urandom);
            case ($urandom_range(3))
                0:       prio = PRIORITY_BITS'($urandom_range(7));
                1:       prio = PRIORITY_BITS'($urandom);
                2:       prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default: prio = 16'h8000 + PRIORITY_BITS'($urandom_range(3));
            endcase
            offer_request(op, tag, prio);
        end
        req_ch.valid = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[array_min_priority_queue] OK");
        else
            $display("[array_min_priority_queue] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/apq_pkg.sv
hw/rtl/apq_if.sv
hw/rtl/apq_ram.sv
hw/rtl/apq_head_scan.sv
hw/rtl/array_min_priority_queue.sv
tb/apq_queue_checker.sv
tb/testbench.sv
